[hw/rtl/lbs_pkg.sv]
// ============================================================================
// lbs_pkg
// Shared types and constants for the linear blend skinning block.
// ============================================================================
package lbs_pkg;

   localparam int BONES_DEF          = 256;
   localparam int MAX_INFLUENCES_DEF = 16;
   localparam int WORDS_PER_BONE     = 12;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_INFL  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Classified influence handed from front to back
   typedef struct packed {
      logic               count;   // influence contributes
      logic               last;    // closes the vertex
      logic [15:0]        weight;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } job_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               passthrough;
   } res_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_MUL, BK_ROW, BK_WEIGH, BK_NEXT, BK_DIVSET, BK_DIV, BK_DIVOUT, BK_OUT
   } bk_state_type;

endpackage

[hw/rtl/lbs_front.sv]
// ============================================================================
// lbs_front
// Accepts items, keeps bone valid marks and the influence position count,
// writes matrix words and pushes classified influences into the queue.
// ============================================================================
module lbs_front #(
   parameter int BONES          = lbs_pkg::BONES_DEF,
   parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFLUENCES_DEF,
   parameter int AW             = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           operation,
   input  logic signed [8:0]    bone,
   input  logic [3:0]           element,
   input  logic signed [31:0]   value,
   input  logic signed [31:0]   vertex_x,
   input  logic signed [31:0]   vertex_y,
   input  logic signed [31:0]   vertex_z,
   input  logic [15:0]          weight,
   input  logic                 last,
   input  logic                 wr_hold,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [31:0]          wr_data,
   output logic                 job_valid,
   input  logic                 job_ready,
   output lbs_pkg::job_type     job,
   output logic [AW-1:0]        job_base
);
   import lbs_pkg::*;

   localparam int BW = (BONES > 1) ? $clog2(BONES) : 1;

   logic [BONES-1:0] valid_ff, valid_in;
   logic [6:0]       count_ff, count_in;
   logic             accept, in_range, is_infl;
   logic [BW-1:0]    bidx;

   // Writes wait while queued or running influences may still read the store
   assign is_infl  = (op_type'(operation) == OP_INFL);
   assign in_ready = is_infl ? job_ready
                   : ((op_type'(operation) == OP_WRITE) ? !wr_hold : 1'b1);
   assign accept   = in_valid && in_ready;
   assign in_range = !bone[8] && ({23'd0, bone} < 32'(BONES));
   assign bidx     = BW'(bone[7:0]);

   assign wr_en   = accept && (op_type'(operation) == OP_WRITE) && in_range
                    && (element < 4'(WORDS_PER_BONE));
   assign wr_addr = AW'(bidx) * AW'(WORDS_PER_BONE) + AW'(element);
   assign wr_data = value;

   assign job_valid   = in_valid && is_infl;
   assign job.count   = (count_ff < 7'(MAX_INFLUENCES)) && in_range
                        && (weight != 16'd0) && valid_ff[bidx];
   assign job.last    = last;
   assign job.weight  = weight;
   assign job.vx      = vertex_x;
   assign job.vy      = vertex_y;
   assign job.vz      = vertex_z;
   assign job_base    = AW'(bidx) * AW'(WORDS_PER_BONE);

   // Valid marks and position count
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (accept) begin
         case (op_type'(operation))
            OP_WRITE: if (wr_en) valid_in[bidx] = 1'b1;
            OP_CLEAR: valid_in = '0;
            OP_INFL: begin
               if (last) count_in = 7'd0;
               else if (count_ff < 7'd127) count_in = count_ff + 7'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end
endmodule

[hw/rtl/lbs_queue.sv]
// ============================================================================
// lbs_queue
// Short queue between front and back for classified influences.
// ============================================================================
module lbs_queue #(
   parameter int AW = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lbs_pkg::job_type push_job,
   input  logic [AW-1:0]    push_base,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lbs_pkg::job_type pop_job,
   output logic [AW-1:0]    pop_base
);
   import lbs_pkg::*;

   job_type       job_ff  [QUEUE_DEPTH];
   logic [AW-1:0] base_ff [QUEUE_DEPTH];
   logic          wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = job_ff[rp_ff];
   assign pop_base   = base_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wp_ff]  <= push_job;
         base_ff[wp_ff] <= push_base;
      end
   end
endmodule

[hw/rtl/lbs_back.sv]
// ============================================================================
// lbs_back
// Matrix memory, per-influence transform and weighting, and the final
// serial divide with truncation and saturation.
// ============================================================================
module lbs_back #(
   parameter int AW    = 12,
   parameter int DEPTH = 3072
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [31:0]      wr_data,
   input  logic             job_valid,
   output logic             job_ready,
   input  lbs_pkg::job_type job_in,
   input  logic [AW-1:0]    job_base,
   output logic             busy,
   output logic             res_valid,
   input  logic             res_ready,
   output lbs_pkg::res_type res
);
   import lbs_pkg::*;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_ff;

   bk_state_type  st_ff, st_in;
   job_type       job_ff, job_nx;
   logic [AW-1:0] base_ff, base_nx;
   logic [1:0]    row_ff, row_nx;
   logic [1:0]    col_ff, col_nx;
   logic [AW-1:0] raddr;
   logic signed [63:0] prod_ff, prod_nx;
   logic signed [63:0] t_ff, t_nx;
   logic signed [63:0] acc_ff [3];
   logic signed [63:0] acc_nx [3];
   logic [23:0]   tot_ff, tot_nx;
   logic [6:0]    dcnt_ff, dcnt_nx;
   logic [63:0]   rem_ff, rem_nx;
   logic [77:0]   quo_ff, quo_nx;
   logic          neg_ff, neg_nx;
   res_type       wres_ff, wres_nx;
   res_type       res_ff, res_nx;
   logic          rv_ff, rv_nx;
   logic signed [31:0] vsel;
   logic signed [63:0] w_hi, w_lo, wsum;
   logic signed [52:0] whw;
   logic [29:0]   wlo_p;
   logic [64:0]   trial;
   logic [63:0]   mag;
   logic [31:0]   sat;

   // Matrix memory, one read port; address of the next step so rd_ff is ready
   assign raddr = base_nx + AW'({row_nx, col_nx});
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[raddr];
   end

   assign job_ready = (st_ff == BK_IDLE);
   assign busy      = (st_ff == BK_MUL) || (st_ff == BK_ROW)
                      || (st_ff == BK_WEIGH) || (st_ff == BK_NEXT);
   assign res_valid = rv_ff;
   assign res       = res_ff;

   always_comb begin
      case (col_ff)
         2'd0:    vsel = job_ff.vx;
         2'd1:    vsel = job_ff.vy;
         default: vsel = job_ff.vz;
      endcase
      w_hi  = t_ff >>> 14;
      w_lo  = t_ff - (w_hi <<< 14);
      whw   = $signed(w_hi[35:0]) * $signed({1'b0, job_ff.weight});
      wlo_p = w_lo[13:0] * job_ff.weight;
      wsum  = 64'(whw) + {48'd0, wlo_p[29:14]};
      trial = {rem_ff, quo_ff[77]} - {41'd0, tot_ff};
      mag   = acc_ff[row_ff][63] ? (64'd0 - acc_ff[row_ff]) : acc_ff[row_ff];
   end

   // Saturate the Q16.16 quotient
   always_comb begin
      if (neg_ff) sat = (quo_ff > 78'h80000000) ? 32'h80000000 : 32'(78'd0 - quo_ff);
      else        sat = (quo_ff > 78'h7FFFFFFF) ? 32'h7FFFFFFF : quo_ff[31:0];
   end

   always_comb begin
      st_in  = st_ff;
      job_nx = job_ff;  base_nx = base_ff;
      row_nx = row_ff;  col_nx = col_ff;
      prod_nx = prod_ff; t_nx = t_ff;
      acc_nx = acc_ff;  tot_nx = tot_ff;
      dcnt_nx = dcnt_ff; rem_nx = rem_ff; quo_nx = quo_ff; neg_nx = neg_ff;
      wres_nx = wres_ff;
      res_nx = res_ff;  rv_nx = rv_ff && !res_ready;
      case (st_ff)
         BK_IDLE: if (job_valid && job_ready) begin
            job_nx = job_in; base_nx = job_base;
            row_nx = 2'd0; col_nx = 2'd0; t_nx = '0;
            if (job_in.count) st_in = BK_MUL;
            else st_in = job_in.last ? BK_DIVSET : BK_IDLE;
            if (job_in.count) tot_nx = tot_ff + 24'(job_in.weight);
         end
         BK_MUL: begin
            // word for (row, col) is in rd_ff
            if (col_ff == 2'd3) t_nx = t_ff + 64'($signed(rd_ff));
            else begin
               prod_nx = $signed(rd_ff) * 64'(vsel);
               t_nx    = t_ff;
            end
            st_in = (col_ff == 2'd3) ? BK_WEIGH : BK_ROW;
         end
         BK_ROW: begin
            t_nx   = t_ff + (prod_ff >>> 16);
            col_nx = col_ff + 2'd1;
            st_in  = BK_MUL;
         end
         BK_WEIGH: begin
            acc_nx[row_ff] = acc_ff[row_ff] + wsum;
            t_nx  = '0;
            col_nx = 2'd0;
            st_in = BK_NEXT;
         end
         BK_NEXT: begin
            if (row_ff == 2'd2) begin
               row_nx = 2'd0;
               st_in  = job_ff.last ? BK_DIVSET : BK_IDLE;
            end else begin
               row_nx = row_ff + 2'd1;
               st_in  = BK_MUL;
            end
         end
         BK_DIVSET: begin
            if (tot_ff == 24'd0) begin
               wres_nx = {job_ff.vx, job_ff.vy, job_ff.vz, 1'b1};
               st_in   = BK_OUT;
            end else begin
               // divide |acc| * 2^14 by the total
               neg_nx = acc_ff[row_ff][63];
               quo_nx = {mag, 14'd0}; rem_nx = '0; dcnt_nx = 7'd0;
               st_in  = BK_DIV;
            end
         end
         BK_DIV: begin
            quo_nx = {quo_ff[76:0], !trial[64]};
            rem_nx = trial[64] ? {rem_ff[62:0], quo_ff[77]} : trial[63:0];
            dcnt_nx = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd77) st_in = BK_DIVOUT;
         end
         BK_DIVOUT: begin
            case (row_ff)
               2'd0:    wres_nx.pos_x = sat;
               2'd1:    wres_nx.pos_y = sat;
               default: wres_nx.pos_z = sat;
            endcase
            wres_nx.passthrough = 1'b0;
            if (row_ff == 2'd2) begin row_nx = 2'd0; st_in = BK_OUT; end
            else begin row_nx = row_ff + 2'd1; st_in = BK_DIVSET; end
         end
         BK_OUT: if (!rv_ff || res_ready) begin
            rv_nx  = 1'b1;
            res_nx = wres_ff;
            acc_nx[0] = '0; acc_nx[1] = '0; acc_nx[2] = '0;
            tot_nx = '0;
            st_in = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= BK_IDLE;
         rv_ff  <= 1'b0;
         tot_ff <= '0;
         acc_ff[0] <= '0; acc_ff[1] <= '0; acc_ff[2] <= '0;
         row_ff <= '0; col_ff <= '0;
      end else begin
         st_ff  <= st_in;
         rv_ff  <= rv_nx;
         tot_ff <= tot_nx;
         acc_ff <= acc_nx;
         row_ff <= row_nx; col_ff <= col_nx;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_nx; base_ff <= base_nx;
      prod_ff <= prod_nx; t_ff <= t_nx;
      dcnt_ff <= dcnt_nx; rem_ff <= rem_nx; quo_ff <= quo_nx; neg_ff <= neg_nx;
      wres_ff <= wres_nx;
      res_ff <= res_nx;
   end
endmodule

[hw/rtl/linear_blend_skin_vertex.sv]
// ============================================================================
// linear_blend_skin_vertex
// Fixed-point linear blend skinning of one vertex over a stream of items.
// ============================================================================
// channel | dir | content
// req_    | in  | operation, bone, element, value, vertex, weight; last
// rsp_    | out | pos_x, pos_y, pos_z; passthrough
// Clear and unused items are always taken; a write waits while an influence
// is queued or being transformed. A counted influence holds the back while it
// reads each matrix row word by word, applies it to the vertex and weighs the
// result; a skipped one is taken when idle. The last influence adds three
// 78-step serial divides, or a passthrough if no weight was counted, and an
// output step. Reset clears valid marks, counts and accumulators; a stall on
// rsp_ holds the next result in the back and fills the two-entry queue.
// ============================================================================
module linear_blend_skin_vertex #(
   parameter int BONES          = lbs_pkg::BONES_DEF,
   parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFLUENCES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: operation[1:0], bone[10:2], element[14:11], value[46:15],
   //        vertex_x[78:47], vertex_y[110:79], vertex_z[142:111],
   //        weight[158:143], zero fill to 160
   input  logic [159:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
   output logic [95:0]  rsp_tdata,
   // tuser: passthrough
   output logic         rsp_tuser
);
   import lbs_pkg::*;

   localparam int DEPTH = BONES * WORDS_PER_BONE;
   localparam int AW    = $clog2(DEPTH);

   logic          wr_en, fj_valid, fj_ready, bj_valid, bj_ready;
   logic          bk_busy, wr_hold;
   logic [AW-1:0] wr_addr, fj_base, bj_base;
   logic [31:0]   wr_data;
   job_type       fj, bj;
   res_type       r;

   // Matrix writes wait for influences that still read the store
   assign wr_hold = bj_valid || bk_busy;

   lbs_front #(.BONES(BONES), .MAX_INFLUENCES(MAX_INFLUENCES), .AW(AW)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .operation(req_tdata[1:0]), .bone(req_tdata[10:2]),
      .element(req_tdata[14:11]), .value(req_tdata[46:15]),
      .vertex_x(req_tdata[78:47]), .vertex_y(req_tdata[110:79]),
      .vertex_z(req_tdata[142:111]), .weight(req_tdata[158:143]),
      .last(req_tlast), .wr_hold,
      .wr_en, .wr_addr, .wr_data,
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj), .job_base(fj_base)
   );

   lbs_queue #(.AW(AW)) u_queue (
      .clock, .reset,
      .push_valid(fj_valid), .push_ready(fj_ready), .push_job(fj), .push_base(fj_base),
      .pop_valid(bj_valid), .pop_ready(bj_ready), .pop_job(bj), .pop_base(bj_base)
   );

   lbs_back #(.AW(AW), .DEPTH(DEPTH)) u_back (
      .clock, .reset,
      .wr_en, .wr_addr, .wr_data,
      .job_valid(bj_valid), .job_ready(bj_ready), .job_in(bj), .job_base(bj_base),
      .busy(bk_busy),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(r)
   );

   assign rsp_tdata = {r.pos_z, r.pos_y, r.pos_x};
   assign rsp_tuser = r.passthrough;
endmodule
